/* hw/rtl/rsc_pkg.sv */
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and helpers of the RPN stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int WORD_BITS   = 48;
  localparam int FRAC_BITS   = 16;

  localparam int CNT_BITS  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_BITS  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int STEP_BITS = $clog2(NUM_BITS + 1);

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_ADD    = 3'd1,
    CMD_SUB    = 3'd2,
    CMD_MUL    = 3'd3,
    CMD_DIV    = 3'd4,
    CMD_FINISH = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_FEW   = 3'd1,
    STS_DIV0  = 3'd2,
    STS_COUNT = 3'd3,
    STS_OVF   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CALC,
    ST_COMMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    AS_IDLE,
    AS_RUN,
    AS_DONE
  } alu_state_e;

  typedef struct packed {
    logic [2:0]                  command;
    logic signed [WORD_BITS-1:0] operand_value;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]                  status;
    logic signed [WORD_BITS-1:0] result_value;
    logic [CNT_BITS-1:0]         stack_count;
    logic                        is_final;
  } out_beat_t;

  typedef struct packed {
    logic start;
    cmd_e op;
  } alu_req_t;

  // saturate a magnitude with sign; hi_nz flags bits above the word
  function automatic logic [WORD_BITS-1:0] sat_mag(input logic neg, input logic hi_nz,
                                                   input logic [WORD_BITS-1:0] lo);
    logic [WORD_BITS-1:0] r;
    if (neg) begin
      if (hi_nz || (lo[WORD_BITS-1] && (|lo[WORD_BITS-2:0]))) begin
        r = WORD_MIN;
      end else begin
        r = {WORD_BITS{1'b0}} - lo;
      end
    end else begin
      if (hi_nz || lo[WORD_BITS-1]) begin
        r = WORD_MAX;
      end else begin
        r = lo;
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/rpn_stack_calculator_unit.sv */
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit
// Reverse Polish evaluator on a bounded stack of signed Q31.16 words.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per command:
// push, add, subtract, multiply, divide or finish. Output channel
// (out_valid_o/out_ready_i/out_data_o): exactly one beat per command with
// status, top of stack (or final answer), entry count and a finish flag.
// Push, finish, errors and unused codes skip the arithmetic unit; add,
// subtract, multiply and divide run through the bit-serial arithmetic unit,
// which handles one bit per cycle (48 word bits, 64 dividend bits for
// divide). One command is in flight at a time; the next is accepted in the
// cycle after the result is loaded into the output register.
// A stalled output holds its beat; the next command is still accepted and
// worked on, and waits before commit until the output register is free.
// Reset empties the stack and clears the sticky error; stack contents are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rsc_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsc_pkg::out_beat_t  out_data_o
);

  localparam int W  = rsc_pkg::WORD_BITS;
  localparam int CW = rsc_pkg::CNT_BITS;
  localparam int IW = rsc_pkg::IDX_BITS;

  rsc_pkg::ctrl_state_e state_q, state_d;
  rsc_pkg::status_e     err_q, err_d;
  logic [CW-1:0]        sp_q, sp_d;
  logic [W-1:0]         top_q, top_d;
  rsc_pkg::cmd_e        cmd_q;
  logic [W-1:0]         val_q;
  logic [W-1:0]         res_q;
  logic                 out_valid_q;
  rsc_pkg::out_beat_t   out_q, out_d;

  rsc_pkg::alu_req_t alu_req;
  logic              alu_done;
  logic [W-1:0]      alu_result;
  logic [W-1:0]      nos;
  logic [CW-1:0]     sp_m2;
  logic              is_arith;
  logic              top_zero;
  logic              arith_go;
  logic              commit;
  logic              mem_we;
  logic [IW-1:0]     mem_waddr;
  logic [W-1:0]      mem_wdata;
  rsc_pkg::status_e  fin_status;

  assign sp_m2    = sp_q - CW'(2);
  assign is_arith = (cmd_q inside {rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB,
                                   rsc_pkg::CMD_MUL, rsc_pkg::CMD_DIV});
  assign top_zero = (top_q == {W{1'b0}});
  assign arith_go = (err_q == rsc_pkg::STS_OK) && is_arith && (sp_q >= CW'(2)) &&
                    !((cmd_q == rsc_pkg::CMD_DIV) && top_zero);

  rsc_stack u_stack (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (sp_m2[IW-1:0]),
    .rdata_o (nos)
  );

  rsc_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (nos),
    .b_i      (top_q),
    .done_o   (alu_done),
    .result_o (alu_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsc_pkg::ST_IDLE;
      err_q       <= rsc_pkg::STS_OK;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        err_q       <= err_d;
        sp_q        <= sp_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= rsc_pkg::cmd_e'(in_data_i.command);
      val_q <= in_data_i.operand_value;
    end
    if (alu_done) begin
      res_q <= alu_result;
    end
    if (commit) begin
      top_q <= top_d;
      out_q <= out_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    alu_req    = '{start: 1'b0, op: cmd_q};
    commit     = 1'b0;
    case (state_q)
      rsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = rsc_pkg::ST_DECODE;
        end
      end
      rsc_pkg::ST_DECODE: begin
        if (arith_go) begin
          alu_req.start = 1'b1;
          state_d       = rsc_pkg::ST_CALC;
        end else begin
          state_d = rsc_pkg::ST_COMMIT;
        end
      end
      rsc_pkg::ST_CALC: begin
        if (alu_done) begin
          state_d = rsc_pkg::ST_COMMIT;
        end
      end
      rsc_pkg::ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          commit  = 1'b1;
          state_d = rsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    err_d      = err_q;
    sp_d       = sp_q;
    top_d      = top_q;
    mem_we     = 1'b0;
    mem_waddr  = sp_q[IW-1:0];
    mem_wdata  = val_q;
    fin_status = rsc_pkg::STS_OK;
    out_d      = '0;
    if (cmd_q == rsc_pkg::CMD_FINISH) begin
      if (err_q != rsc_pkg::STS_OK) begin
        fin_status = err_q;
      end else if (sp_q != CW'(1)) begin
        fin_status = rsc_pkg::STS_COUNT;
      end
      err_d              = rsc_pkg::STS_OK;
      sp_d               = '0;
      out_d.status       = fin_status;
      out_d.result_value = (fin_status == rsc_pkg::STS_OK) ? top_q : {W{1'b0}};
      out_d.stack_count  = '0;
      out_d.is_final     = 1'b1;
    end else begin
      if (err_q == rsc_pkg::STS_OK) begin
        case (cmd_q)
          rsc_pkg::CMD_PUSH: begin
            if (sp_q >= CW'(rsc_pkg::STACK_DEPTH)) begin
              err_d = rsc_pkg::STS_OVF;
            end else begin
              mem_we = commit;
              sp_d   = sp_q + CW'(1);
              top_d  = val_q;
            end
          end
          rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB, rsc_pkg::CMD_MUL, rsc_pkg::CMD_DIV: begin
            if (sp_q < CW'(2)) begin
              err_d = rsc_pkg::STS_FEW;
            end else if ((cmd_q == rsc_pkg::CMD_DIV) && top_zero) begin
              err_d = rsc_pkg::STS_DIV0;
            end else begin
              mem_we    = commit;
              mem_waddr = sp_m2[IW-1:0];
              mem_wdata = res_q;
              sp_d      = sp_q - CW'(1);
              top_d     = res_q;
            end
          end
          default: begin
          end
        endcase
      end
      out_d.status       = err_d;
      out_d.result_value = (sp_d != '0) ? top_d : {W{1'b0}};
      out_d.stack_count  = sp_d;
      out_d.is_final     = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hw/rtl/rsc_stack.sv */
// ----------------------------------------------------------------------------
// rsc_stack
// Operand stack storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsc_stack (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [rsc_pkg::IDX_BITS-1:0]  waddr_i,
  input  logic [rsc_pkg::WORD_BITS-1:0] wdata_i,
  input  logic [rsc_pkg::IDX_BITS-1:0]  raddr_i,
  output logic [rsc_pkg::WORD_BITS-1:0] rdata_o
);

  logic [rsc_pkg::WORD_BITS-1:0] mem_q [rsc_pkg::STACK_DEPTH];
  logic [rsc_pkg::WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/rsc_alu.sv */
// ----------------------------------------------------------------------------
// rsc_alu
// Bit-serial arithmetic: ripple add/subtract, shift-add multiply and
// restoring divide, one bit per cycle, with saturation at the end.
// ----------------------------------------------------------------------------
module rsc_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rsc_pkg::alu_req_t             req_i,
  input  logic [rsc_pkg::WORD_BITS-1:0] a_i,
  input  logic [rsc_pkg::WORD_BITS-1:0] b_i,
  output logic                          done_o,
  output logic [rsc_pkg::WORD_BITS-1:0] result_o
);

  localparam int W  = rsc_pkg::WORD_BITS;
  localparam int F  = rsc_pkg::FRAC_BITS;
  localparam int NW = rsc_pkg::NUM_BITS;
  localparam int SW = rsc_pkg::STEP_BITS;

  rsc_pkg::alu_state_e state_q, state_d;
  rsc_pkg::cmd_e       op_q, op_d;
  logic [SW-1:0]       cnt_q, cnt_d;
  logic [NW-1:0]       x_q, x_d;
  logic [W-1:0]        acc_q, acc_d;
  logic [W-1:0]        mag_q, mag_d;
  logic                carry_q, carry_d;
  logic                neg_q, neg_d;
  logic                nbe_q, nbe_d;

  logic [W-1:0]   ma, mb;
  logic [1:0]     bit_sum;
  logic [W:0]     mul_sum;
  logic [W:0]     div_rs;
  logic [W+1:0]   div_diff;
  logic           div_ge;
  logic [2*W-1:0] prod;
  logic [NW:0]    quo;
  logic           add_ovf;

  assign ma       = a_i[W-1] ? ({W{1'b0}} - a_i) : a_i;
  assign mb       = b_i[W-1] ? ({W{1'b0}} - b_i) : b_i;
  assign bit_sum  = {1'b0, x_q[0]} + {1'b0, mag_q[0]} + {1'b0, carry_q};
  assign mul_sum  = {1'b0, acc_q} + (x_q[0] ? {1'b0, mag_q} : {(W+1){1'b0}});
  assign div_rs   = {acc_q, x_q[NW-1]};
  assign div_diff = {1'b0, div_rs} - {2'b00, mag_q};
  assign div_ge   = ~div_diff[W+1];
  assign prod     = {acc_q, x_q[W-1:0]};
  assign quo      = {1'b0, x_q};
  assign add_ovf  = (neg_q == nbe_q) && (acc_q[W-1] != neg_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsc_pkg::AS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    cnt_q   <= cnt_d;
    x_q     <= x_d;
    acc_q   <= acc_d;
    mag_q   <= mag_d;
    carry_q <= carry_d;
    neg_q   <= neg_d;
    nbe_q   <= nbe_d;
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    cnt_d    = cnt_q;
    x_d      = x_q;
    acc_d    = acc_q;
    mag_d    = mag_q;
    carry_d  = carry_q;
    neg_d    = neg_q;
    nbe_d    = nbe_q;
    done_o   = 1'b0;
    result_o = acc_q;
    case (state_q)
      rsc_pkg::AS_IDLE: begin
        if (req_i.start) begin
          state_d = rsc_pkg::AS_RUN;
          op_d    = req_i.op;
          acc_d   = {W{1'b0}};
          carry_d = 1'b0;
          neg_d   = a_i[W-1] ^ b_i[W-1];
          nbe_d   = b_i[W-1];
          cnt_d   = SW'(W);
          case (req_i.op)
            rsc_pkg::CMD_ADD: begin
              x_d   = NW'(a_i);
              mag_d = b_i;
              neg_d = a_i[W-1];
            end
            rsc_pkg::CMD_SUB: begin
              x_d     = NW'(a_i);
              mag_d   = ~b_i;
              carry_d = 1'b1;
              neg_d   = a_i[W-1];
              nbe_d   = ~b_i[W-1];
            end
            rsc_pkg::CMD_MUL: begin
              x_d   = NW'(mb);
              mag_d = ma;
            end
            default: begin
              x_d   = NW'(ma) << F;
              mag_d = mb;
              cnt_d = SW'(NW);
            end
          endcase
        end
      end
      rsc_pkg::AS_RUN: begin
        cnt_d = cnt_q - SW'(1);
        if (cnt_q == SW'(1)) begin
          state_d = rsc_pkg::AS_DONE;
        end
        case (op_q)
          rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB: begin
            acc_d   = {bit_sum[0], acc_q[W-1:1]};
            carry_d = bit_sum[1];
            x_d     = x_q >> 1;
            mag_d   = mag_q >> 1;
          end
          rsc_pkg::CMD_MUL: begin
            acc_d = mul_sum[W:1];
            x_d   = NW'({mul_sum[0], x_q[W-1:1]});
          end
          default: begin
            acc_d = div_ge ? div_diff[W-1:0] : div_rs[W-1:0];
            x_d   = {x_q[NW-2:0], div_ge};
          end
        endcase
      end
      rsc_pkg::AS_DONE: begin
        done_o  = 1'b1;
        state_d = rsc_pkg::AS_IDLE;
        case (op_q)
          rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB: begin
            if (add_ovf) begin
              result_o = neg_q ? rsc_pkg::WORD_MIN : rsc_pkg::WORD_MAX;
            end else begin
              result_o = acc_q;
            end
          end
          rsc_pkg::CMD_MUL: begin
            result_o = rsc_pkg::sat_mag(neg_q, |prod[2*W-1:W+F], prod[W+F-1:F]);
          end
          default: begin
            result_o = rsc_pkg::sat_mag(neg_q, |quo[NW:W], x_q[W-1:0]);
          end
        endcase
      end
      default: begin
        state_d = rsc_pkg::AS_IDLE;
      end
    endcase
  end

endmodule
